// ===== rtl/core/fftm_pkg.sv =====
// Shared types and constants of the FFT magnitude spectrum block.
// Used by fft_magnitude_spectrum, fftm_mag and fftm_checker; depends on nothing.
package fftm_pkg;

  localparam real PI = 3.14159265358979323846;

  localparam int MAG_BITS = 28;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PAD,
    ST_RD_E,
    ST_RD_O,
    ST_MUL,
    ST_ADD,
    ST_WR_E,
    ST_WR_O,
    ST_RD_BIN,
    ST_MAG
  } fft_state_t;

  typedef enum logic [2:0] {
    MG_IDLE,
    MG_SQ,
    MG_SUM,
    MG_ROOT,
    MG_DONE
  } mag_state_t;

endpackage

// ===== rtl/core/fft_magnitude_spectrum.sv =====
// Top level of the FFT magnitude spectrum block: sample store, butterfly
// sequencer and twiddle ROM. Depends on fftm_pkg and fftm_mag.
//
// Usage: drive start with an item while busy is low; the item is taken at
// that edge. A push (in_kind = 0) writes one sample in bit-reversed order
// into the work memory. A push with in_frame_end set, or the push that fills
// the frame, pads the rest with zeros (one entry per cycle) and runs an
// in-place radix-2 transform on one butterfly unit, each butterfly stepping
// through read even, read odd, multiply, add, write even and write odd, with
// busy high all along.
// Other pushes only write the sample; busy stays low. A push after a
// transform drops it and starts a new frame.
// A read (in_kind = 1) gives one result beat, marked by out_valid for one
// cycle. While no transform is held it comes the cycle after acceptance with
// magnitude 0 and out_spectrum_ready 0. Otherwise the beat follows one memory
// read, a bit-serial square and a digit-serial square root at the work width
// W = SAMPLE_BITS + log2(FFT_POINTS) + 1 (29 by default).
// The receiver cannot stall: each beat is shown once.
// Reset clears the frame and returns to idle, where the ready flag is cleared; memory contents are not cleared.
module fft_magnitude_spectrum #(
  parameter int FFT_POINTS  = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_kind,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample,
  input  logic                                in_frame_end,
  input  logic [$clog2(FFT_POINTS)-1:0]       in_bin_index,
  output logic                                out_valid,
  output logic [fftm_pkg::MAG_BITS-1:0]       out_magnitude,
  output logic                                out_spectrum_ready
);

  localparam int LOG  = $clog2(FFT_POINTS);
  localparam int W    = SAMPLE_BITS + LOG + 1;
  localparam int HALF = FFT_POINTS / 2;
  localparam int TWA  = (LOG > 1) ? LOG - 1 : 1;
  localparam int SW   = $clog2(LOG + 1);
  localparam int PW   = W + 16;

  typedef logic [31:0] tw_rom_t [HALF];

  function automatic tw_rom_t build_tw();
    tw_rom_t rom;
    real     ang;
    int      c;
    int      s;
    for (int k = 0; k < HALF; k++) begin
      ang = 2.0 * fftm_pkg::PI * k / FFT_POINTS;
      c = $rtoi($floor($cos(ang) * 32768.0 + 0.5));
      s = $rtoi($floor(-$sin(ang) * 32768.0 + 0.5));
      if (c > 32767) c = 32767;
      if (s > 32767) s = 32767;
      rom[k] = {c[15:0], s[15:0]};
    end
    return rom;
  endfunction

  localparam tw_rom_t TW_ROM = build_tw();

  function automatic logic [LOG-1:0] bit_rev(input logic [LOG-1:0] x);
    logic [LOG-1:0] r;
    for (int i = 0; i < LOG; i++) r[i] = x[LOG-1-i];
    return r;
  endfunction

  logic [2*W-1:0] mem [FFT_POINTS];

  fftm_pkg::fft_state_t state_r, state_nxt;
  logic [LOG:0]         fill_r;
  logic                 done_r;
  logic [SW-1:0]        stage_r;
  logic [LOG-1:0]       bfly_r;
  logic [2*W-1:0]       rd_q, e_r, ne_r, no_r;
  logic [31:0]          tw_q;
  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic                 out_valid_r;
  logic [fftm_pkg::MAG_BITS-1:0] out_mag_r;
  logic                 out_ready_r;

  logic                 accept, push_acc, read_acc;
  logic [LOG-1:0]       push_idx;
  logic [LOG:0]         push_cnt;
  logic                 frame_close;
  logic [LOG-1:0]       hmask, half_bit, ie, io, kk;
  logic [TWA-1:0]       wk;
  logic                 last_bfly, last_stage;
  logic                 mem_we;
  logic [LOG-1:0]       waddr, raddr;
  logic [2*W-1:0]       wdata;
  logic                 mag_start, mag_done;
  logic [W-1:0]         mag_root;
  logic signed [W-1:0]  o_re, o_im, e_re, e_im;
  logic signed [15:0]   w_re, w_im;
  logic [W+16:0]        tr_full, ti_full;
  logic [W-1:0]         tr_w, ti_w;
  logic [W-1:0]         sample_w;

  assign accept      = start && !busy;
  assign push_acc    = accept && (in_kind == fftm_pkg::KIND_PUSH);
  assign read_acc    = accept && (in_kind == fftm_pkg::KIND_READ);
  assign push_idx    = done_r ? '0 : fill_r[LOG-1:0];
  assign push_cnt    = {1'b0, push_idx} + (LOG+1)'(1);
  assign frame_close = in_frame_end || (push_cnt == (LOG+1)'(FFT_POINTS));
  assign sample_w    = {{(W-SAMPLE_BITS){in_sample[SAMPLE_BITS-1]}}, in_sample};

  // butterfly addressing: insert a zero at the stage bit for the even index
  assign hmask      = ~({LOG{1'b1}} << stage_r);
  assign half_bit   = {{(LOG-1){1'b0}}, 1'b1} << stage_r;
  assign ie         = ((bfly_r & ~hmask) << 1) | (bfly_r & hmask);
  assign io         = ie | half_bit;
  assign kk         = (bfly_r & hmask) << (SW'(LOG - 1) - stage_r);
  assign wk         = kk[TWA-1:0];
  assign last_bfly  = (bfly_r == LOG'(HALF - 1));
  assign last_stage = (stage_r == SW'(LOG - 1));

  assign o_re = rd_q[2*W-1:W];
  assign o_im = rd_q[W-1:0];
  assign e_re = e_r[2*W-1:W];
  assign e_im = e_r[W-1:0];
  assign w_re = tw_q[31:16];
  assign w_im = tw_q[15:0];

  // round half up, then keep the work width
  assign tr_full = (W+17)'(p_rr_r) - (W+17)'(p_ii_r) + (W+17)'(16384);
  assign ti_full = (W+17)'(p_ri_r) + (W+17)'(p_ir_r) + (W+17)'(16384);
  assign tr_w    = tr_full[W+14:15];
  assign ti_w    = ti_full[W+14:15];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fftm_pkg::ST_IDLE: begin
        if (push_acc && frame_close) begin
          if (push_cnt == (LOG+1)'(FFT_POINTS)) state_nxt = fftm_pkg::ST_RD_E;
          else state_nxt = fftm_pkg::ST_PAD;
        end else if (read_acc && done_r) begin
          state_nxt = fftm_pkg::ST_RD_BIN;
        end
      end
      fftm_pkg::ST_PAD: begin
        if (fill_r == (LOG+1)'(FFT_POINTS - 1)) state_nxt = fftm_pkg::ST_RD_E;
      end
      fftm_pkg::ST_RD_E:   state_nxt = fftm_pkg::ST_RD_O;
      fftm_pkg::ST_RD_O:   state_nxt = fftm_pkg::ST_MUL;
      fftm_pkg::ST_MUL:    state_nxt = fftm_pkg::ST_ADD;
      fftm_pkg::ST_ADD:    state_nxt = fftm_pkg::ST_WR_E;
      fftm_pkg::ST_WR_E:   state_nxt = fftm_pkg::ST_WR_O;
      fftm_pkg::ST_WR_O: begin
        if (last_bfly && last_stage) state_nxt = fftm_pkg::ST_IDLE;
        else state_nxt = fftm_pkg::ST_RD_E;
      end
      fftm_pkg::ST_RD_BIN: state_nxt = fftm_pkg::ST_MAG;
      fftm_pkg::ST_MAG:    if (mag_done) state_nxt = fftm_pkg::ST_IDLE;
      default:             state_nxt = fftm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state_r != fftm_pkg::ST_IDLE);
    mem_we    = 1'b0;
    waddr     = ie;
    wdata     = ne_r;
    raddr     = in_bin_index;
    mag_start = 1'b0;
    unique case (state_r)
      fftm_pkg::ST_IDLE: begin
        mem_we = push_acc;
        waddr  = bit_rev(push_idx);
        wdata  = {sample_w, {W{1'b0}}};
      end
      fftm_pkg::ST_PAD: begin
        mem_we = 1'b1;
        waddr  = bit_rev(fill_r[LOG-1:0]);
        wdata  = '0;
      end
      fftm_pkg::ST_RD_E:   raddr = ie;
      fftm_pkg::ST_RD_O:   raddr = io;
      fftm_pkg::ST_WR_E: begin
        mem_we = 1'b1;
        waddr  = ie;
        wdata  = ne_r;
      end
      fftm_pkg::ST_WR_O: begin
        mem_we = 1'b1;
        waddr  = io;
        wdata  = no_r;
      end
      fftm_pkg::ST_RD_BIN: mag_start = 1'b1;
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
    tw_q <= TW_ROM[wk];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fftm_pkg::ST_IDLE;
      fill_r      <= '0;
      done_r      <= 1'b0;
      stage_r     <= '0;
      bfly_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      unique case (state_r)
        fftm_pkg::ST_IDLE: begin
          if (push_acc) begin
            done_r  <= 1'b0;
            fill_r  <= push_cnt;
            stage_r <= '0;
            bfly_r  <= '0;
          end else if (read_acc && !done_r) begin
            out_valid_r <= 1'b1;
          end
        end
        fftm_pkg::ST_PAD: fill_r <= fill_r + (LOG+1)'(1);
        fftm_pkg::ST_WR_O: begin
          if (last_bfly) begin
            bfly_r <= '0;
            if (last_stage) done_r <= 1'b1;
            else stage_r <= stage_r + SW'(1);
          end else begin
            bfly_r <= bfly_r + LOG'(1);
          end
        end
        fftm_pkg::ST_MAG: if (mag_done) out_valid_r <= 1'b1;
        default: begin
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      fftm_pkg::ST_IDLE: begin
        out_mag_r   <= '0;
        out_ready_r <= 1'b0;
      end
      fftm_pkg::ST_RD_O: e_r <= rd_q;
      fftm_pkg::ST_MUL: begin
        p_rr_r <= PW'(o_re) * PW'(w_re);
        p_ii_r <= PW'(o_im) * PW'(w_im);
        p_ri_r <= PW'(o_re) * PW'(w_im);
        p_ir_r <= PW'(o_im) * PW'(w_re);
      end
      fftm_pkg::ST_ADD: begin
        ne_r <= {W'(e_re + tr_w), W'(e_im + ti_w)};
        no_r <= {W'(e_re - tr_w), W'(e_im - ti_w)};
      end
      fftm_pkg::ST_MAG: begin
        out_mag_r   <= fftm_pkg::MAG_BITS'(mag_root);
        out_ready_r <= 1'b1;
      end
      default: begin
        out_ready_r <= out_ready_r;
      end
    endcase
  end

  fftm_mag #(
    .W(W)
  ) u_mag (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mag_start),
    .re    (rd_q[2*W-1:W]),
    .im    (rd_q[W-1:0]),
    .done  (mag_done),
    .root  (mag_root)
  );

  assign out_valid          = out_valid_r;
  assign out_magnitude      = out_mag_r;
  assign out_spectrum_ready = out_ready_r;

endmodule

// ===== rtl/core/fftm_mag.sv =====
// Magnitude unit: floor(sqrt(re^2 + im^2)) with a bit-serial square and a
// digit-by-digit square root. Depends on fftm_pkg.
module fftm_mag #(
  parameter int W = 29
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [W-1:0] re,
  input  logic signed [W-1:0] im,
  output logic                done,
  output logic [W-1:0]        root
);

  localparam int CW = $clog2(W + 1);

  fftm_pkg::mag_state_t state_r, state_nxt;
  logic [CW-1:0]  cnt_r;
  logic [2*W-1:0] mr_r, mi_r, sr_r, si_r, rad_r;
  logic [W-1:0]   br_r, bi_r, root_r;
  logic [W+1:0]   rem_r;
  logic [W-1:0]   abs_re, abs_im;
  logic [W+2:0]   rem_t, trial;
  logic           last;

  assign abs_re = re[W-1] ? (~re + W'(1)) : re;
  assign abs_im = im[W-1] ? (~im + W'(1)) : im;
  assign last   = (cnt_r == CW'(W - 1));
  assign rem_t  = {rem_r[W:0], rad_r[2*W-1:2*W-2]};
  assign trial  = {1'b0, root_r, 2'b01};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fftm_pkg::MG_IDLE: if (start) state_nxt = fftm_pkg::MG_SQ;
      fftm_pkg::MG_SQ:   if (last) state_nxt = fftm_pkg::MG_SUM;
      fftm_pkg::MG_SUM:  state_nxt = fftm_pkg::MG_ROOT;
      fftm_pkg::MG_ROOT: if (last) state_nxt = fftm_pkg::MG_DONE;
      fftm_pkg::MG_DONE: state_nxt = fftm_pkg::MG_IDLE;
      default:           state_nxt = fftm_pkg::MG_IDLE;
    endcase
  end

  always_comb begin
    done = (state_r == fftm_pkg::MG_DONE);
    root = root_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fftm_pkg::MG_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      fftm_pkg::MG_IDLE: begin
        mr_r  <= {{W{1'b0}}, abs_re};
        mi_r  <= {{W{1'b0}}, abs_im};
        br_r  <= abs_re;
        bi_r  <= abs_im;
        sr_r  <= '0;
        si_r  <= '0;
        cnt_r <= '0;
      end
      fftm_pkg::MG_SQ: begin
        // shift-add: one multiplier bit per cycle for both squares
        if (br_r[0]) sr_r <= sr_r + mr_r;
        if (bi_r[0]) si_r <= si_r + mi_r;
        mr_r  <= mr_r << 1;
        mi_r  <= mi_r << 1;
        br_r  <= br_r >> 1;
        bi_r  <= bi_r >> 1;
        cnt_r <= last ? '0 : cnt_r + CW'(1);
      end
      fftm_pkg::MG_SUM: begin
        rad_r  <= sr_r + si_r;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
      end
      fftm_pkg::MG_ROOT: begin
        // one result bit per cycle from the top pair of radicand bits
        if (rem_t >= trial) begin
          rem_r  <= (W+2)'(rem_t - trial);
          root_r <= {root_r[W-2:0], 1'b1};
        end else begin
          rem_r  <= (W+2)'(rem_t);
          root_r <= {root_r[W-2:0], 1'b0};
        end
        rad_r <= rad_r << 2;
        cnt_r <= cnt_r + CW'(1);
      end
      fftm_pkg::MG_DONE: begin
        cnt_r <= '0;
      end
      default: begin
        cnt_r <= '0;
      end
    endcase
  end

endmodule

// ===== rtl/core/fftm_checker.sv =====
// Port-level assertions for fft_magnitude_spectrum, attached by bind.
// Depends on fftm_pkg.
module fftm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          in_kind,
  input logic                          in_frame_end,
  input logic                          out_valid,
  input logic [fftm_pkg::MAG_BITS-1:0] out_magnitude,
  input logic                          out_spectrum_ready
);

  a_not_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_spectrum_ready |-> out_magnitude == '0)
    else $error("magnitude nonzero without a held spectrum");

  a_push_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_kind == fftm_pkg::KIND_PUSH |=> !out_valid)
    else $error("result beat after a push");

  a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_kind == fftm_pkg::KIND_PUSH && in_frame_end |=> busy)
    else $error("frame close did not start the transform");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("activity right after reset");

endmodule

bind fft_magnitude_spectrum fftm_checker u_fftm_checker (.*);
